@@ design/psd_pkg.sv @@
// Shared types, constants and byte-assembly functions for the capture stream deframer.
package psd_pkg;

    // Word kinds on the result channel.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Error codes carried with an error word.
    localparam logic [2:0] ERR_MAGIC         = 3'd0;
    localparam logic [2:0] ERR_VERSION       = 3'd1;
    localparam logic [2:0] ERR_LINK_KIND     = 3'd2;
    localparam logic [2:0] ERR_SHORT_GLOBAL  = 3'd3;
    localparam logic [2:0] ERR_TRUNC_HEADER  = 3'd4;
    localparam logic [2:0] ERR_TRUNC_PAYLOAD = 3'd5;

    // Capture file format constants.
    localparam logic [31:0] MAGIC_USEC     = 32'hA1B2C3D4;
    localparam logic [31:0] MAGIC_NSEC     = 32'hA1B23C4D;
    localparam logic [15:0] VER_MAJOR_REQ  = 16'd2;
    localparam logic [15:0] VER_MINOR_REQ  = 16'd4;
    localparam logic [31:0] LINK_ETHERNET  = 32'd1;
    localparam logic [4:0]  GLOBAL_LEN     = 5'd24;
    localparam logic [4:0]  RECORD_LEN     = 5'd16;

    // Header bytes held before the final byte of the global header arrives.
    localparam int HDR_KEEP = 23;

    typedef enum logic [1:0] {
        PH_GLOBAL,
        PH_RECORD,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } psd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] stamp_seconds;
        logic [31:0] stamp_fraction;
        logic        nanosecond_resolution;
        logic [31:0] captured_length;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [2:0]  error_code;
    } psd_out_t;

    // Result of processing one item, handed to the output register.
    typedef struct packed {
        logic     vld;
        psd_out_t word;
    } psd_res_t;

    // Assemble a 32-bit field from four stream bytes in arrival order.
    function automatic logic [31:0] get32(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic big);
        logic [31:0] val;
        if (big)
        begin
            val = {b0, b1, b2, b3};
        end
        else
        begin
            val = {b3, b2, b1, b0};
        end
        return val;
    endfunction

    // Assemble a 16-bit field from two stream bytes in arrival order.
    function automatic logic [15:0] get16(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic big);
        logic [15:0] val;
        if (big)
        begin
            val = {b0, b1};
        end
        else
        begin
            val = {b1, b0};
        end
        return val;
    endfunction

endpackage

@@ design/psd_input_reg.sv @@
// Input register stage: captures one stream word and holds it until the parser takes it.
module psd_input_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             stream_valid,
    output logic             stream_stall,
    input  psd_pkg::psd_in_t stream_data,
    input  logic             take,
    output logic             item_valid,
    output psd_pkg::psd_in_t item
);

    logic             vld_reg;
    logic             vld_next;
    psd_pkg::psd_in_t item_reg;
    logic             accept;

    // The stage is free when empty or when its word leaves in this cycle.
    assign stream_stall = vld_reg && !take;
    assign accept       = stream_valid && !stream_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= stream_data;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

@@ design/psd_parser.sv @@
// Parser: stream phase machine, header byte shift line and result formation.
module psd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  psd_pkg::psd_in_t  item,
    input  logic              out_ready,
    output logic              take,
    output psd_pkg::psd_res_t res
);

    psd_pkg::phase_t phase_reg;
    psd_pkg::phase_t phase_next;
    logic [4:0]      cnt_reg;
    logic [4:0]      cnt_next;
    logic            big_reg;
    logic            big_next;
    logic            nano_reg;
    logic            nano_next;
    logic [31:0]     remain_reg;
    logic [31:0]     remain_next;
    logic [7:0]      hdr_reg [psd_pkg::HDR_KEEP];
    logic [7:0]      hdr_next [psd_pkg::HDR_KEEP];
    logic            shift;

    logic [31:0]     magic_le;
    logic [31:0]     magic_be;
    logic            le_ok;
    logic            be_ok;
    logic            big_sel;
    logic [15:0]     ver_major;
    logic [15:0]     ver_minor;
    logic [31:0]     link_word;
    logic [31:0]     rec_seconds;
    logic [31:0]     rec_fraction;
    logic [31:0]     rec_length;

    assign take = item_valid && out_ready;

    // Newest byte sits at index 0; at header completion byte i of a header of
    // length N is found at index N-2-i, and the final byte is still on the input.
    assign magic_le  = psd_pkg::get32(hdr_reg[22], hdr_reg[21], hdr_reg[20], hdr_reg[19], 1'b0);
    assign magic_be  = psd_pkg::get32(hdr_reg[22], hdr_reg[21], hdr_reg[20], hdr_reg[19], 1'b1);
    assign le_ok     = (magic_le == psd_pkg::MAGIC_USEC) || (magic_le == psd_pkg::MAGIC_NSEC);
    assign be_ok     = (magic_be == psd_pkg::MAGIC_USEC) || (magic_be == psd_pkg::MAGIC_NSEC);
    assign big_sel   = !le_ok;
    assign ver_major = psd_pkg::get16(hdr_reg[18], hdr_reg[17], big_sel);
    assign ver_minor = psd_pkg::get16(hdr_reg[16], hdr_reg[15], big_sel);
    assign link_word = psd_pkg::get32(hdr_reg[2], hdr_reg[1], hdr_reg[0], item.data_byte,
                                      big_sel);

    assign rec_seconds  = psd_pkg::get32(hdr_reg[14], hdr_reg[13], hdr_reg[12], hdr_reg[11],
                                         big_reg);
    assign rec_fraction = psd_pkg::get32(hdr_reg[10], hdr_reg[9], hdr_reg[8], hdr_reg[7],
                                         big_reg);
    assign rec_length   = psd_pkg::get32(hdr_reg[6], hdr_reg[5], hdr_reg[4], hdr_reg[3],
                                         big_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        big_next    = big_reg;
        nano_next   = nano_reg;
        remain_next = remain_reg;
        shift       = 1'b0;
        res         = '0;

        if (take)
        begin
            if (item.end_of_stream)
            begin
                unique case (phase_reg)
                    psd_pkg::PH_GLOBAL:
                    begin
                        res.vld             = 1'b1;
                        res.word.kind       = psd_pkg::KIND_ERROR;
                        res.word.error_code = psd_pkg::ERR_SHORT_GLOBAL;
                    end
                    psd_pkg::PH_RECORD:
                    begin
                        res.vld = 1'b1;
                        if (cnt_reg == 5'd0)
                        begin
                            res.word.kind = psd_pkg::KIND_END;
                        end
                        else
                        begin
                            res.word.kind       = psd_pkg::KIND_ERROR;
                            res.word.error_code = psd_pkg::ERR_TRUNC_HEADER;
                        end
                    end
                    psd_pkg::PH_PAYLOAD:
                    begin
                        res.vld             = 1'b1;
                        res.word.kind       = psd_pkg::KIND_ERROR;
                        res.word.error_code = psd_pkg::ERR_TRUNC_PAYLOAD;
                    end
                    psd_pkg::PH_ERROR:
                    begin
                        res.vld = 1'b0;
                    end
                endcase
                phase_next  = psd_pkg::PH_GLOBAL;
                cnt_next    = 5'd0;
                big_next    = 1'b0;
                nano_next   = 1'b0;
                remain_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    psd_pkg::PH_GLOBAL:
                    begin
                        shift = 1'b1;
                        if (cnt_reg == psd_pkg::GLOBAL_LEN - 5'd1)
                        begin
                            cnt_next = 5'd0;
                            if (!le_ok && !be_ok)
                            begin
                                res.vld             = 1'b1;
                                res.word.kind       = psd_pkg::KIND_ERROR;
                                res.word.error_code = psd_pkg::ERR_MAGIC;
                                phase_next          = psd_pkg::PH_ERROR;
                            end
                            else
                            begin
                                big_next  = big_sel;
                                nano_next = le_ok ? (magic_le == psd_pkg::MAGIC_NSEC)
                                                  : (magic_be == psd_pkg::MAGIC_NSEC);
                                if (ver_major != psd_pkg::VER_MAJOR_REQ ||
                                    ver_minor != psd_pkg::VER_MINOR_REQ)
                                begin
                                    res.vld             = 1'b1;
                                    res.word.kind       = psd_pkg::KIND_ERROR;
                                    res.word.error_code = psd_pkg::ERR_VERSION;
                                    phase_next          = psd_pkg::PH_ERROR;
                                end
                                else if (link_word != psd_pkg::LINK_ETHERNET)
                                begin
                                    res.vld             = 1'b1;
                                    res.word.kind       = psd_pkg::KIND_ERROR;
                                    res.word.error_code = psd_pkg::ERR_LINK_KIND;
                                    phase_next          = psd_pkg::PH_ERROR;
                                end
                                else
                                begin
                                    phase_next = psd_pkg::PH_RECORD;
                                end
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 5'd1;
                        end
                    end
                    psd_pkg::PH_RECORD:
                    begin
                        shift = 1'b1;
                        if (cnt_reg == psd_pkg::RECORD_LEN - 5'd1)
                        begin
                            cnt_next                       = 5'd0;
                            res.vld                        = 1'b1;
                            res.word.kind                  = psd_pkg::KIND_HEADER;
                            res.word.stamp_seconds         = rec_seconds;
                            res.word.stamp_fraction        = rec_fraction;
                            res.word.nanosecond_resolution = nano_reg;
                            res.word.captured_length       = rec_length;
                            remain_next                    = rec_length;
                            if (rec_length != 32'd0)
                            begin
                                phase_next = psd_pkg::PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 5'd1;
                        end
                    end
                    psd_pkg::PH_PAYLOAD:
                    begin
                        res.vld               = 1'b1;
                        res.word.kind         = psd_pkg::KIND_PAYLOAD;
                        res.word.payload_byte = item.data_byte;
                        res.word.last_byte    = (remain_reg <= 32'd1);
                        if (remain_reg <= 32'd1)
                        begin
                            remain_next = '0;
                            phase_next  = psd_pkg::PH_RECORD;
                            cnt_next    = 5'd0;
                        end
                        else
                        begin
                            remain_next = remain_reg - 32'd1;
                        end
                    end
                    psd_pkg::PH_ERROR:
                    begin
                        res.vld = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        hdr_next[0] = item.data_byte;
        for (int i = 1; i < psd_pkg::HDR_KEEP; i++)
        begin
            hdr_next[i] = hdr_reg[i - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= psd_pkg::PH_GLOBAL;
            cnt_reg    <= 5'd0;
            big_reg    <= 1'b0;
            nano_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            big_reg    <= big_next;
            nano_reg   <= nano_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            hdr_reg <= hdr_next;
        end
    end

endmodule

@@ design/psd_out_reg.sv @@
// Result register: holds one finished word until the receiver takes it.
module psd_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  psd_pkg::psd_res_t res,
    input  logic              take,
    output logic              out_ready,
    output logic              result_valid,
    input  logic              result_stall,
    output psd_pkg::psd_out_t result_data
);

    logic              vld_reg;
    logic              vld_next;
    psd_pkg::psd_out_t word_reg;

    // Free when empty or when the held word is being delivered now.
    assign out_ready = !vld_reg || !result_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (out_ready)
        begin
            vld_next = take && res.vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res.vld)
        begin
            word_reg <= res.word;
        end
    end

    assign result_valid = vld_reg;
    assign result_data  = word_reg;

endmodule

@@ design/pcap_stream_deframer_unit.sv @@
// Top level of the capture stream deframer: input register, parser and result register.
//
// The stream channel (stream_valid, stream_stall, stream_data) carries one word per
// capture-file byte, or an end-of-stream word. The result channel (result_valid,
// result_stall, result_data) carries packet headers, payload bytes, error words and
// the clean end-of-capture word; many stream words produce no result.
// A stream word is registered at its accepting edge and handled by the parser once the
// result register can take a word; its result, if any, is loaded into the result
// register at the edge that ends that pass. Throughput is one stream word per clock
// while the receiver does not stall, set by the parser pass between the input register
// and the result register.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to
// waiting for a global header with little-endian, microsecond defaults; an end-of-stream
// word returns the parser to that state once processed, so a new stream may follow.
// When the receiver stalls while a result is held, the parser pauses and the input
// register keeps its word; stream_stall rises once that register is occupied, so at
// most two words wait inside the block. Nothing is dropped or repeated.
// Errors are reported once; later data words are swallowed until end of stream.
module pcap_stream_deframer_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stream_valid,
    output logic              stream_stall,
    input  psd_pkg::psd_in_t  stream_data,
    output logic              result_valid,
    input  logic              result_stall,
    output psd_pkg::psd_out_t result_data
);

    logic              item_valid;
    psd_pkg::psd_in_t  item;
    logic              take;
    logic              out_ready;
    psd_pkg::psd_res_t res;

    // Input register stage.
    psd_input_reg u_input_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .stream_data  (stream_data),
        .take         (take),
        .item_valid   (item_valid),
        .item         (item)
    );

    // Phase machine and header assembly.
    psd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .res        (res)
    );

    // Result register toward the receiver.
    psd_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .take         (take),
        .out_ready    (out_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // A held result that the receiver refuses must back up into the stream side
    // whenever the input register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall && item_valid) |-> stream_stall)
        else $error("stream not stalled behind a blocked result");

    // An accepted stream word must be present in the input register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stream_valid && !stream_stall) |=> item_valid)
        else $error("accepted stream word lost");

    // Error words only carry defined error codes and a zero captured length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.kind == psd_pkg::KIND_ERROR) |->
        (result_data.error_code <= psd_pkg::ERR_TRUNC_PAYLOAD &&
         result_data.captured_length == 32'd0))
        else $error("malformed error word");

endmodule

@@ verif/tb_pcap_stream_deframer_unit.sv @@
// Self-checking testbench for the capture stream deframer, with random stimulus and a predictor.
`timescale 1ns / 1ps

module tb_pcap_stream_deframer_unit;

    // Random stream words to send after the directed plan, which is about 250 words.
    localparam int RANDOM_WORDS = 540;
    // Length of the long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES  = 150;
    // Cycles without any accepted word before the run is declared hung. The longest
    // legal quiet stretch is a hold-off plus a long sender gap, well under this.
    localparam int STALL_LIMIT  = 2000;
    // Extra cycles after the last expected result.
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 10;

    // Row operations of the directed plan. A global header row carries the magic in a,
    // {major, minor} in b and the link type in c. A record row carries seconds in a,
    // fraction in b and captured length in c. A bytes row sends c bytes, the first
    // one being a[7:0] and the rest random. An end row sends the end-of-stream word.
    typedef enum {ROW_GLOBAL, ROW_RECORD, ROW_BYTES, ROW_END} row_op_t;

    // When typed is set, the last word of the row must give exactly the typed
    // result (want_valid says whether any result is due at all).
    typedef struct {
        row_op_t           op;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       c;
        bit                big;
        bit                typed;
        bit                want_valid;
        psd_pkg::psd_out_t want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              stream_valid;
    logic              stream_stall;
    psd_pkg::psd_in_t  stream_data;
    logic              result_valid;
    logic              result_stall;
    psd_pkg::psd_out_t result_data;

    // Predicted capture parser state, kept in step with every accepted stream word.
    psd_pkg::phase_t cap_phase;
    logic [4:0]      cap_count;
    logic [7:0]      cap_hdr [0:23];
    bit              cap_big;
    bit              cap_nsec;
    logic [31:0]     cap_left;

    // Results still owed by the block, oldest first.
    psd_pkg::psd_out_t pending_results [$];
    // Words built for the next stream, not yet offered.
    psd_pkg::psd_in_t  stage_q [$];
    plan_row_t         plan_rows [$];

    int words_sent;
    int fault_count;
    // The sender drops its gaps while sender_quiet is set; the receiver drops its
    // random stalls while rx_eager is set. Each bump of hold_orders asks the
    // receiver for one long hold-off.
    bit sender_quiet;
    bit rx_eager;
    int hold_orders;

    pcap_stream_deframer_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .stream_data  (stream_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_capture_state();
        cap_phase = psd_pkg::PH_GLOBAL;
        cap_count = '0;
        for (int k = 0; k < 24; k++)
            cap_hdr[k] = '0;
        cap_big  = 1'b0;
        cap_nsec = 1'b0;
        cap_left = '0;
    endfunction

    // A 32-bit header field starting at byte offset at, in the given byte order.
    function automatic logic [31:0] hdr_u32(input int at, input bit big);
        if (big)
            return {cap_hdr[at], cap_hdr[at + 1], cap_hdr[at + 2], cap_hdr[at + 3]};
        return {cap_hdr[at + 3], cap_hdr[at + 2], cap_hdr[at + 1], cap_hdr[at]};
    endfunction

    function automatic logic [15:0] hdr_u16(input int at, input bit big);
        if (big)
            return {cap_hdr[at], cap_hdr[at + 1]};
        return {cap_hdr[at + 1], cap_hdr[at]};
    endfunction

    function automatic psd_pkg::psd_out_t error_word(input logic [2:0] code);
        psd_pkg::psd_out_t r;
        r = '0;
        r.kind       = psd_pkg::KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    // Advances the predicted parser by one stream word. Returns 1 when the word
    // produces a result, which is then placed in r.
    function automatic bit predict_word(input psd_pkg::psd_in_t w,
                                        output psd_pkg::psd_out_t r);
        bit          emits;
        logic [31:0] le_magic;
        logic [31:0] be_magic;
        r = '0;
        if (w.end_of_stream)
        begin
            // The end marker always returns the parser to its reset state. It reports
            // where the stream stopped, except after an error, which was already given.
            emits = 1'b1;
            case (cap_phase)
                psd_pkg::PH_GLOBAL:
                begin
                    r = error_word(psd_pkg::ERR_SHORT_GLOBAL);
                end
                psd_pkg::PH_RECORD:
                begin
                    if (cap_count == 0)
                        r.kind = psd_pkg::KIND_END;
                    else
                        r = error_word(psd_pkg::ERR_TRUNC_HEADER);
                end
                psd_pkg::PH_PAYLOAD:
                begin
                    r = error_word(psd_pkg::ERR_TRUNC_PAYLOAD);
                end
                default:
                begin
                    emits = 1'b0;
                end
            endcase
            reset_capture_state();
            return emits;
        end
        case (cap_phase)
            psd_pkg::PH_GLOBAL:
            begin
                cap_hdr[cap_count] = w.data_byte;
                cap_count++;
                if (cap_count != psd_pkg::GLOBAL_LEN)
                    return 1'b0;
                cap_count = '0;
                // The magic is tried in both byte orders; the one that matches sets the
                // order of every later field and the timestamp resolution.
                le_magic = hdr_u32(0, 1'b0);
                be_magic = hdr_u32(0, 1'b1);
                if (le_magic == psd_pkg::MAGIC_USEC || le_magic == psd_pkg::MAGIC_NSEC)
                begin
                    cap_big  = 1'b0;
                    cap_nsec = (le_magic == psd_pkg::MAGIC_NSEC);
                end
                else if (be_magic == psd_pkg::MAGIC_USEC || be_magic == psd_pkg::MAGIC_NSEC)
                begin
                    cap_big  = 1'b1;
                    cap_nsec = (be_magic == psd_pkg::MAGIC_NSEC);
                end
                else
                begin
                    r = error_word(psd_pkg::ERR_MAGIC);
                    cap_phase = psd_pkg::PH_ERROR;
                    return 1'b1;
                end
                if (hdr_u16(4, cap_big) != psd_pkg::VER_MAJOR_REQ ||
                    hdr_u16(6, cap_big) != psd_pkg::VER_MINOR_REQ)
                begin
                    r = error_word(psd_pkg::ERR_VERSION);
                    cap_phase = psd_pkg::PH_ERROR;
                    return 1'b1;
                end
                if (hdr_u32(20, cap_big) != psd_pkg::LINK_ETHERNET)
                begin
                    r = error_word(psd_pkg::ERR_LINK_KIND);
                    cap_phase = psd_pkg::PH_ERROR;
                    return 1'b1;
                end
                cap_phase = psd_pkg::PH_RECORD;
                return 1'b0;
            end
            psd_pkg::PH_RECORD:
            begin
                cap_hdr[cap_count] = w.data_byte;
                cap_count++;
                if (cap_count != psd_pkg::RECORD_LEN)
                    return 1'b0;
                cap_count = '0;
                // The original-length field at offset 12 plays no part.
                r.kind                  = psd_pkg::KIND_HEADER;
                r.stamp_seconds         = hdr_u32(0, cap_big);
                r.stamp_fraction        = hdr_u32(4, cap_big);
                r.nanosecond_resolution = cap_nsec;
                r.captured_length       = hdr_u32(8, cap_big);
                cap_left = r.captured_length;
                // A zero-length packet goes straight back to waiting for a record header.
                if (cap_left != 0)
                    cap_phase = psd_pkg::PH_PAYLOAD;
                else
                    cap_phase = psd_pkg::PH_RECORD;
                return 1'b1;
            end
            psd_pkg::PH_PAYLOAD:
            begin
                r.kind         = psd_pkg::KIND_PAYLOAD;
                r.payload_byte = w.data_byte;
                r.last_byte    = (cap_left <= 1);
                if (cap_left > 0)
                    cap_left--;
                if (cap_left == 0)
                begin
                    cap_phase = psd_pkg::PH_RECORD;
                    cap_count = '0;
                end
                return 1'b1;
            end
            default:
            begin
                // After an error, data words are swallowed without a result.
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stream builders: they only queue words, offer_word sends them.
    // ------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b);
        psd_pkg::psd_in_t w;
        w.data_byte     = b;
        w.end_of_stream = 1'b0;
        stage_q = {stage_q, w};
    endtask

    // The data byte of an end word is ignored by the block, so it is random.
    task automatic put_end();
        psd_pkg::psd_in_t w;
        w.data_byte     = 8'($urandom_range(0, 255));
        w.end_of_stream = 1'b1;
        stage_q = {stage_q, w};
    endtask

    task automatic put_u16(input logic [15:0] v, input bit big);
        if (big)
        begin
            put_byte(v[15:8]);
            put_byte(v[7:0]);
        end
        else
        begin
            put_byte(v[7:0]);
            put_byte(v[15:8]);
        end
    endtask

    task automatic put_u32(input logic [31:0] v, input bit big);
        if (big)
        begin
            put_u16(v[31:16], 1'b1);
            put_u16(v[15:0], 1'b1);
        end
        else
        begin
            put_u16(v[15:0], 1'b0);
            put_u16(v[31:16], 1'b0);
        end
    endtask

    // Global header: magic, version, zone offset, accuracy, snapshot length, link type.
    task automatic put_global(input logic [31:0] magic, input bit big,
                              input logic [15:0] major, input logic [15:0] minor,
                              input logic [31:0] link);
        put_u32(magic, big);
        put_u16(major, big);
        put_u16(minor, big);
        put_u32($urandom, big);
        put_u32($urandom, big);
        put_u32($urandom, big);
        put_u32(link, big);
    endtask

    // Record header: seconds, fraction, captured length, original length.
    task automatic put_record(input logic [31:0] secs, input logic [31:0] frac,
                              input logic [31:0] len, input bit big);
        put_u32(secs, big);
        put_u32(frac, big);
        put_u32(len, big);
        put_u32($urandom, big);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one word after an optional gap, holds it until the block takes it, and
    // then books the expected result. A pinned word books the typed result instead of
    // the predicted one; the predictor still runs so that its state stays in step.
    task automatic offer_word(input psd_pkg::psd_in_t w, input bit pinned,
                              input bit pin_valid, input psd_pkg::psd_out_t pin_word);
        int                gap;
        int                roll;
        bit                emits;
        psd_pkg::psd_out_t r;
        gap = 0;
        if (!sender_quiet)
        begin
            roll = $urandom_range(0, 99);
            if (roll >= 96)
                gap = $urandom_range(6, 30);
            else if (roll >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            stream_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_valid <= 1'b1;
        stream_data  <= w;
        // Inputs and registered outputs still show their pre-edge values here, so
        // this is the handshake as the block saw it at this edge.
        do
            @(posedge clk);
        while (stream_stall);
        emits = predict_word(w, r);
        if (pinned)
        begin
            emits = pin_valid;
            r     = pin_word;
        end
        if (emits)
            pending_results = {pending_results, r};
        words_sent++;
    endtask

    task automatic flush_stage(input bit typed, input bit want_valid,
                               input psd_pkg::psd_out_t want);
        psd_pkg::psd_in_t w;
        while (stage_q.size() != 0)
        begin
            w = stage_q.pop_front();
            offer_word(w, typed && (stage_q.size() == 0), want_valid, want);
        end
    endtask

    // Sender pause: nothing is offered until every booked result has come back.
    task automatic drain_results();
        stream_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic add_row(input row_op_t op, input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input bit big, input bit typed,
                           input bit want_valid, input psd_pkg::psd_out_t want);
        plan_row_t row;
        row.op         = op;
        row.a          = a;
        row.b          = b;
        row.c          = c;
        row.big        = big;
        row.typed      = typed;
        row.want_valid = want_valid;
        row.want       = want;
        plan_rows = {plan_rows, row};
    endtask

    // One random capture stream. Most are well formed with random content; the rest
    // are cut short in the global header, carry a broken global header followed by
    // noise, or stop inside a record header or a payload.
    task automatic build_capture(input bit force_good);
        int          pick;
        int          npk;
        int          roll;
        int          cut;
        bit          big;
        logic [31:0] magic;
        logic [31:0] link;
        logic [31:0] len;
        logic [15:0] major;
        logic [15:0] minor;
        pick  = force_good ? 99 : $urandom_range(0, 99);
        big   = 1'($urandom_range(0, 1));
        magic = $urandom_range(0, 1) ? psd_pkg::MAGIC_NSEC : psd_pkg::MAGIC_USEC;
        major = psd_pkg::VER_MAJOR_REQ;
        minor = psd_pkg::VER_MINOR_REQ;
        link  = psd_pkg::LINK_ETHERNET;
        if (pick < 8)
        begin
            repeat ($urandom_range(0, 23)) put_byte(8'($urandom_range(0, 255)));
            put_end();
            return;
        end
        if (pick < 14)
            magic = $urandom;
        else if (pick < 20)
        begin
            if ($urandom_range(0, 1))
                major = 16'($urandom_range(0, 3));
            else
                minor = 16'($urandom_range(0, 7));
        end
        else if (pick < 26)
            link = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : 32'($urandom);
        put_global(magic, big, major, minor, link);
        if (pick < 26)
        begin
            // Whatever follows a broken header should be swallowed.
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
            put_end();
            return;
        end
        npk = force_good ? 3 : $urandom_range(0, 4);
        for (int k = 0; k < npk; k++)
        begin
            roll = $urandom_range(0, 99);
            if (force_good && k == 0)
                len = 32'd32;
            else if (roll < 70)
                len = $urandom_range(0, 8);
            else
                len = $urandom_range(9, 40);
            put_record($urandom, $urandom, len, big);
            repeat (len) put_byte(8'($urandom_range(0, 255)));
        end
        roll = force_good ? 0 : $urandom_range(0, 99);
        if (roll >= 88)
        begin
            // Stop inside a payload; now and then the length is a full 32-bit value.
            len = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(1, 40));
            put_record($urandom, $urandom, len, big);
            if (len != 0)
            begin
                cut = (len > 40) ? $urandom_range(0, 40) : $urandom_range(0, len - 1);
                repeat (cut) put_byte(8'($urandom_range(0, 255)));
            end
        end
        else if (roll >= 75)
        begin
            // Stop inside a record header.
            repeat ($urandom_range(1, 15)) put_byte(8'($urandom_range(0, 255)));
        end
        put_end();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, eager stretches and the long hold-off.
    // ------------------------------------------------------------------

    initial
    begin : receiver
        int run;
        int seen;
        run  = 0;
        seen = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_orders != seen)
            begin
                seen = hold_orders;
                run  = HOLD_CYCLES;
            end
            if (run > 0)
            begin
                result_stall <= 1'b1;
                run--;
            end
            else if (rx_eager || $urandom_range(0, 99) < 55)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                // About one stall in ten is long; the others are short.
                result_stall <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    run = $urandom_range(8, 40);
                else
                    run = $urandom_range(0, 2);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_fault(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (fault_count < MAX_REPORTS)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        fault_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            note_fault({"result field ", name}, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        psd_pkg::psd_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                note_fault("result word with nothing pending, kind", '0, result_data.kind);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, result_data.kind);
                compare_field("stamp_seconds", want.stamp_seconds, result_data.stamp_seconds);
                compare_field("stamp_fraction", want.stamp_fraction,
                              result_data.stamp_fraction);
                compare_field("nanosecond_resolution", want.nanosecond_resolution,
                              result_data.nanosecond_resolution);
                compare_field("captured_length", want.captured_length,
                              result_data.captured_length);
                compare_field("payload_byte", want.payload_byte, result_data.payload_byte);
                compare_field("last_byte", want.last_byte, result_data.last_byte);
                compare_field("error_code", want.error_code, result_data.error_code);
            end
        end
    end

    // Ends the run as failed once neither channel has moved a word before the idle count reaches STALL_LIMIT.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (stream_valid && !stream_stall) || (result_valid && !result_stall))
                idle = 0;
            else
                idle++;
        end
        $display("pcap_stream_deframer_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        plan_row_t         row;
        psd_pkg::psd_out_t clean_end;
        int                directed_words;
        int                capture_no;

        rst_n        = 1'b0;
        stream_valid = 1'b0;
        stream_data  = '0;
        words_sent   = 0;
        fault_count  = 0;
        sender_quiet = 1'b0;
        rx_eager     = 1'b0;
        hold_orders  = 0;
        reset_capture_state();
        clean_end      = '0;
        clean_end.kind = psd_pkg::KIND_END;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan. Error codes and the clean end are typed in; packet headers
        // and payload bytes come from the predictor.
        // An end marker straight after reset, and one after a few bytes of global header.
        add_row(ROW_END, 0, 0, 0, 0, 1, 1, error_word(psd_pkg::ERR_SHORT_GLOBAL));
        add_row(ROW_BYTES, 32'hFF, 0, 5, 0, 0, 0, '0);
        add_row(ROW_END, 0, 0, 0, 0, 1, 1, error_word(psd_pkg::ERR_SHORT_GLOBAL));
        // Unknown magic; the bytes after it are swallowed and the end marker is silent.
        add_row(ROW_GLOBAL, 32'h12345678, {psd_pkg::VER_MAJOR_REQ, psd_pkg::VER_MINOR_REQ},
                psd_pkg::LINK_ETHERNET, 0, 1, 1, error_word(psd_pkg::ERR_MAGIC));
        add_row(ROW_BYTES, 32'h00, 0, 3, 0, 1, 0, '0);
        add_row(ROW_END, 0, 0, 0, 0, 1, 0, '0);
        // Version 2.3 in a little-endian microsecond file.
        add_row(ROW_GLOBAL, psd_pkg::MAGIC_USEC, {16'd2, 16'd3}, psd_pkg::LINK_ETHERNET,
                0, 1, 1, error_word(psd_pkg::ERR_VERSION));
        add_row(ROW_END, 0, 0, 0, 0, 1, 0, '0);
        // A link type other than Ethernet in a big-endian nanosecond file.
        add_row(ROW_GLOBAL, psd_pkg::MAGIC_NSEC,
                {psd_pkg::VER_MAJOR_REQ, psd_pkg::VER_MINOR_REQ}, 32'h71,
                1, 1, 1, error_word(psd_pkg::ERR_LINK_KIND));
        add_row(ROW_END, 0, 0, 0, 0, 1, 0, '0);
        // Big-endian microsecond file: a zero-length packet, extreme timestamps, and a
        // packet of the largest length cut off inside its payload.
        add_row(ROW_GLOBAL, psd_pkg::MAGIC_USEC,
                {psd_pkg::VER_MAJOR_REQ, psd_pkg::VER_MINOR_REQ}, psd_pkg::LINK_ETHERNET,
                1, 0, 0, '0);
        add_row(ROW_RECORD, 32'h0, 32'h0, 32'h0, 1, 0, 0, '0);
        add_row(ROW_RECORD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd3, 1, 0, 0, '0);
        add_row(ROW_BYTES, 32'hFF, 0, 3, 0, 0, 0, '0);
        add_row(ROW_RECORD, 32'h5A5A5A5A, 32'hA5A5A5A5, 32'hFFFFFFFF, 1, 0, 0, '0);
        add_row(ROW_BYTES, 32'h00, 0, 2, 0, 0, 0, '0);
        add_row(ROW_END, 0, 0, 0, 0, 1, 1, error_word(psd_pkg::ERR_TRUNC_PAYLOAD));
        // Little-endian nanosecond file: a one-byte packet, then a cut record header.
        add_row(ROW_GLOBAL, psd_pkg::MAGIC_NSEC,
                {psd_pkg::VER_MAJOR_REQ, psd_pkg::VER_MINOR_REQ}, psd_pkg::LINK_ETHERNET,
                0, 0, 0, '0);
        add_row(ROW_RECORD, 32'h00000001, 32'd999999999, 32'd1, 0, 0, 0, '0);
        add_row(ROW_BYTES, 32'h80, 0, 1, 0, 0, 0, '0);
        add_row(ROW_BYTES, 32'h7F, 0, 7, 0, 0, 0, '0);
        add_row(ROW_END, 0, 0, 0, 0, 1, 1, error_word(psd_pkg::ERR_TRUNC_HEADER));
        // A clean capture that ends right after a zero-length packet.
        add_row(ROW_GLOBAL, psd_pkg::MAGIC_USEC,
                {psd_pkg::VER_MAJOR_REQ, psd_pkg::VER_MINOR_REQ}, psd_pkg::LINK_ETHERNET,
                0, 0, 0, '0);
        add_row(ROW_RECORD, 32'h12345678, 32'd999999, 32'd0, 0, 0, 0, '0);
        add_row(ROW_END, 0, 0, 0, 0, 1, 1, clean_end);

        foreach (plan_rows[i])
        begin
            row = plan_rows[i];
            case (row.op)
                ROW_GLOBAL:
                begin
                    put_global(row.a, row.big, row.b[31:16], row.b[15:0], row.c);
                end
                ROW_RECORD:
                begin
                    put_record(row.a, row.b, row.c, row.big);
                end
                ROW_BYTES:
                begin
                    put_byte(row.a[7:0]);
                    repeat (row.c - 1) put_byte(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    put_end();
                end
            endcase
            flush_stage(row.typed, row.want_valid, row.want);
        end
        drain_results();
        directed_words = words_sent;

        // Random captures. Each one picks whether the sender and the receiver idle.
        // The third capture runs against a long receiver hold-off with the sender
        // offering back to back, so the block fills and stalls its input; every fifth
        // capture the sender waits until all results are back.
        capture_no = 0;
        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            rx_eager     = ($urandom_range(0, 4) == 0);
            if (capture_no == 2)
            begin
                sender_quiet = 1'b1;
                rx_eager     = 1'b0;
                hold_orders++;
                build_capture(1'b1);
            end
            else
            begin
                build_capture(1'b0);
            end
            flush_stage(1'b0, 1'b0, '0);
            if (capture_no == 2 || capture_no % 5 == 4)
                drain_results();
            capture_no++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        fault_count += pending_results.size();
        if (fault_count == 0)
            $display("pcap_stream_deframer_unit verification clean");
        else
            $display("pcap_stream_deframer_unit verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/psd_pkg.sv
design/psd_input_reg.sv
design/psd_parser.sv
design/psd_out_reg.sv
design/pcap_stream_deframer_unit.sv
verif/tb_pcap_stream_deframer_unit.sv
